>>> hw/rtl/ppms_pkg.sv
// ---------------------------------------------------------------------------
// ppms_pkg
// Shared sizes, types and helpers of the path point moving average smoother.
// ---------------------------------------------------------------------------
package ppms_pkg;

   localparam int MAX_HALF = 8;
   localparam int DEPTH    = 2 * MAX_HALF + 1;
   localparam int COORD_W  = 33;
   localparam int HALF_W   = 4;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int PTR_W    = $clog2(DEPTH + 1);
   localparam int ACC_W    = COORD_W + $clog2(DEPTH);
   localparam int MAG_W    = ACC_W - 1;
   localparam int CNT_W    = $clog2(MAG_W + 1);
   localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(2);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SUM,
      ST_TAIL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_CTR_RD,
      ST_CTR_OUT,
      ST_POST,
      ST_FL_RD,
      ST_FL_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic sum_clear;
      logic rd;
      logic idx_inc;
      logic acc_add;
      logic div_start;
      logic wr_mean;
      logic out_rd;
      logic out_last;
      logic idx_ctr;
      logic idx_flush;
      logic clear_count;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic center;
      logic last;
      logic s_zero;
      logic idx_zero;
      logic idx_end;
      logic div_done;
      logic out_free;
      logic flush_empty;
   } sts_type;

   // circular window address: x is below 2*DEPTH
   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [PTR_W:0] x);
      logic [PTR_W:0] y;
      y = x - (PTR_W + 1)'(DEPTH);
      if (x >= (PTR_W + 1)'(DEPTH)) begin
         wrap_addr = y[ADDR_W-1:0];
      end else begin
         wrap_addr = x[ADDR_W-1:0];
      end
   endfunction

endpackage

>>> hw/rtl/ppms_if.sv
// ---------------------------------------------------------------------------
// ppms_if
// Valid/ready channels for input points and result points.
// ---------------------------------------------------------------------------
interface ppms_req_if import ppms_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] lon_in;
   logic signed [COORD_W-1:0] lat_in;
   logic                      last_in;

   modport source (output valid, output lon_in, output lat_in, output last_in, input ready);
   modport sink   (input valid, input lon_in, input lat_in, input last_in, output ready);
endinterface

interface ppms_rsp_if import ppms_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] lon_out;
   logic signed [COORD_W-1:0] lat_out;
   logic                      last_out;

   modport source (output valid, output lon_out, output lat_out, output last_out, input ready);
   modport sink   (input valid, input lon_out, input lat_out, input last_out, output ready);
endinterface

>>> hw/rtl/ppms_div.sv
// ---------------------------------------------------------------------------
// ppms_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
// ---------------------------------------------------------------------------
module ppms_div import ppms_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [ACC_W-1:0]   dividend,
   input  logic        [PTR_W-1:0]   divisor,
   output logic signed [COORD_W-1:0] quotient,
   output logic                      done
);

   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [PTR_W-1:0] rem_ff, rem_in;
   logic [PTR_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [ACC_W-1:0] abs_val;
   logic [PTR_W:0]   trial;
   logic [PTR_W:0]   diff;
   logic             ge;
   logic [COORD_W-1:0] q_mag;

   assign abs_val = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
   assign trial   = {rem_ff, mag_ff[MAG_W-1]};
   assign ge      = trial >= {1'b0, dvs_ff};
   assign diff    = trial - {1'b0, dvs_ff};
   assign q_mag   = mag_ff[COORD_W-1:0];

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         mag_in  = abs_val[MAG_W-1:0];
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         neg_in  = dividend[ACC_W-1];
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         mag_in = {mag_ff[MAG_W-2:0], ge};
         rem_in = ge ? diff[PTR_W-1:0] : trial[PTR_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = neg_ff ? -$signed(q_mag) : $signed(q_mag);
   assign done     = done_ff;

endmodule

>>> hw/rtl/ppms_ctrl.sv
// ---------------------------------------------------------------------------
// ppms_ctrl
// Sequencer: accept, window sum, divide, center output and end-of-path flush.
// ---------------------------------------------------------------------------
module ppms_ctrl import ppms_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.full) begin
               state_in = ST_SUM;
            end else if (sts.center) begin
               state_in = ST_CTR_RD;
            end else begin
               state_in = ST_POST;
            end
         end
         ST_SUM: begin
            if (sts.idx_end) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL:   state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (sts.div_done && sts.out_free) begin
               state_in = ST_POST;
            end
         end
         ST_CTR_RD: state_in = ST_CTR_OUT;
         ST_CTR_OUT: begin
            if (sts.out_free) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (!sts.last || sts.flush_empty) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FL_RD;
            end
         end
         ST_FL_RD: state_in = ST_FL_OUT;
         ST_FL_OUT: begin
            if (sts.out_free) begin
               state_in = sts.idx_end ? ST_IDLE : ST_FL_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DECIDE: begin
            cmd.sum_clear = sts.full;
            cmd.idx_ctr   = !sts.full && sts.center;
         end
         ST_SUM: begin
            cmd.rd      = 1'b1;
            cmd.idx_inc = 1'b1;
            cmd.acc_add = !sts.idx_zero;
         end
         ST_TAIL:   cmd.acc_add = 1'b1;
         ST_DIV_GO: cmd.div_start = 1'b1;
         ST_DIV_WAIT: begin
            cmd.wr_mean  = sts.div_done && sts.out_free;
            cmd.out_last = sts.last && sts.s_zero;
         end
         ST_CTR_RD: cmd.rd = 1'b1;
         ST_CTR_OUT: begin
            cmd.out_rd   = sts.out_free;
            cmd.out_last = sts.last && sts.s_zero;
         end
         ST_POST: begin
            cmd.clear_count = sts.last && sts.flush_empty;
            cmd.idx_flush   = sts.last && !sts.flush_empty;
         end
         ST_FL_RD: cmd.rd = 1'b1;
         ST_FL_OUT: begin
            cmd.out_rd      = sts.out_free;
            cmd.out_last    = sts.idx_end;
            cmd.idx_inc     = sts.out_free;
            cmd.clear_count = sts.out_free && sts.idx_end;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/ppms_dp.sv
// ---------------------------------------------------------------------------
// ppms_dp
// Window memory, counters, accumulators, dividers and result register.
// ---------------------------------------------------------------------------
module ppms_dp import ppms_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   input  logic                      csr_write_en,
   input  logic [HALF_W-1:0]         csr_write_data,
   input  logic signed [COORD_W-1:0] lon_in,
   input  logic signed [COORD_W-1:0] lat_in,
   input  logic                      last_in,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [COORD_W-1:0] lon_out,
   output logic signed [COORD_W-1:0] lat_out,
   output logic                      last_out
);

   logic [HALF_W-1:0]  half_ff, half_in;
   logic [PTR_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [PTR_W-1:0]   idx_ff, idx_in;
   logic               item_last_ff, item_last_in;
   logic signed [ACC_W-1:0] acc_lon_ff, acc_lon_in;
   logic signed [ACC_W-1:0] acc_lat_ff, acc_lat_in;
   logic               valid_ff, valid_in;
   logic [COORD_W-1:0] res_lon_ff, res_lon_in;
   logic [COORD_W-1:0] res_lat_ff, res_lat_in;
   logic               res_last_ff, res_last_in;

   logic [2*COORD_W-1:0] mem [DEPTH];
   logic [2*COORD_W-1:0] rd_data_ff;

   logic [PTR_W-1:0]   s_w;
   logic [PTR_W-1:0]   len_w;
   logic               out_free;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [2*COORD_W-1:0] wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic signed [COORD_W-1:0] q_lon;
   logic signed [COORD_W-1:0] q_lat;
   logic               done_lon;
   logic               done_lat;
   logic signed [COORD_W-1:0] rd_lon;
   logic signed [COORD_W-1:0] rd_lat;

   // effective half width and window length
   assign s_w   = (32'(half_ff) > MAX_HALF) ? PTR_W'(MAX_HALF) : PTR_W'(half_ff);
   assign len_w = PTR_W'((32'(s_w) << 1) + 1);

   assign out_free = !valid_ff || rsp_ready;
   assign rd_lon   = rd_data_ff[2*COORD_W-1:COORD_W];
   assign rd_lat   = rd_data_ff[COORD_W-1:0];

   always_comb begin
      sts.full        = count_ff == len_w;
      sts.center      = count_ff > s_w;
      sts.last        = item_last_ff;
      sts.s_zero      = s_w == '0;
      sts.idx_zero    = idx_ff == '0;
      sts.idx_end     = idx_ff == count_ff - PTR_W'(1);
      sts.div_done    = done_lon && done_lat;
      sts.out_free    = out_free;
      sts.flush_empty = (s_w == '0) || (count_ff == '0);
   end

   // write port: new point at logical slot count, mean at slot s
   always_comb begin
      wr_en   = cmd.accept || cmd.wr_mean;
      wr_addr = wrap_addr((PTR_W + 1)'(base_ff) + (PTR_W + 1)'(s_w));
      wr_data = {q_lon, q_lat};
      if (cmd.accept) begin
         wr_addr = wrap_addr((PTR_W + 1)'(base_ff) + (PTR_W + 1)'(count_ff));
         wr_data = {lon_in, lat_in};
      end
   end

   assign rd_addr = wrap_addr((PTR_W + 1)'(base_ff) + (PTR_W + 1)'(idx_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      half_in      = half_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      item_last_in = item_last_ff;
      acc_lon_in   = acc_lon_ff;
      acc_lat_in   = acc_lat_ff;
      if (csr_write_en) begin
         half_in  = csr_write_data;
         count_in = '0;
      end
      if (cmd.accept) begin
         item_last_in = last_in;
         if (count_ff == len_w) begin
            base_in = wrap_addr((PTR_W + 1)'(base_ff) + (PTR_W + 1)'(1));
         end else begin
            count_in = count_ff + PTR_W'(1);
         end
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end
      if (cmd.sum_clear) begin
         idx_in     = '0;
         acc_lon_in = '0;
         acc_lat_in = '0;
      end
      if (cmd.idx_ctr) begin
         idx_in = count_ff - PTR_W'(1) - s_w;
      end
      if (cmd.idx_flush) begin
         idx_in = sts.center ? count_ff - s_w : '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + PTR_W'(1);
      end
      if (cmd.acc_add) begin
         acc_lon_in = acc_lon_ff + ACC_W'(rd_lon);
         acc_lat_in = acc_lat_ff + ACC_W'(rd_lat);
      end
   end

   // result register: one word waits here while the window moves on
   always_comb begin
      valid_in    = valid_ff;
      res_lon_in  = res_lon_ff;
      res_lat_in  = res_lat_ff;
      res_last_in = res_last_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (cmd.wr_mean) begin
         valid_in    = 1'b1;
         res_lon_in  = q_lon;
         res_lat_in  = q_lat;
         res_last_in = cmd.out_last;
      end else if (cmd.out_rd) begin
         valid_in    = 1'b1;
         res_lon_in  = rd_lon;
         res_lat_in  = rd_lat;
         res_last_in = cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      item_last_ff <= item_last_in;
      acc_lon_ff   <= acc_lon_in;
      acc_lat_ff   <= acc_lat_in;
      res_lon_ff   <= res_lon_in;
      res_lat_ff   <= res_lat_in;
      res_last_ff  <= res_last_in;
      if (reset) begin
         half_ff  <= HALF_RESET;
         count_ff <= '0;
         base_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         half_ff  <= half_in;
         count_ff <= count_in;
         base_ff  <= base_in;
         valid_ff <= valid_in;
      end
   end

   ppms_div u_div_lon (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_lon_ff),
      .divisor  (len_w),
      .quotient (q_lon),
      .done     (done_lon)
   );

   ppms_div u_div_lat (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_lat_ff),
      .divisor  (len_w),
      .quotient (q_lat),
      .done     (done_lat)
   );

   assign rsp_valid = valid_ff;
   assign lon_out   = res_lon_ff;
   assign lat_out   = res_lat_ff;
   assign last_out  = res_last_ff;

endmodule

>>> hw/rtl/path_point_moving_average_smoother.sv
// Order: a point that completes a full window (2s+1 points) gives its
//   smoothed word after the serial window sum and the divide, a pass-through
//   word after a single window read; the last point flushes the words still held.
// Flow: one point at a time (serial window sum over the one read port, then
//   the 37-step divider when smoothing).
// Reset: synchronous, active high; half width returns to 2, window empty.
// ---------------------------------------------------------------------------
// path_point_moving_average_smoother
// Centered moving average over a stream of path points, in place.
// ---------------------------------------------------------------------------
module path_point_moving_average_smoother import ppms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ppms_req_if.sink          req_ch,
   ppms_rsp_if.source        rsp_ch,
   input  logic              csr_write_en,
   input  logic [HALF_W-1:0] csr_write_data
);

   // Window layout: a circular buffer of DEPTH words (lon and lat side by
   // side), logical slot i at base + i mod DEPTH. Slot 0 is the oldest point.
   // Once the window holds 2s+1 points, a new word advances the base instead
   // of moving data, and the mean is written back at slot s so later windows
   // see the smoothed value.

   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   // controller: decides per word whether to average, pass through or flush
   ppms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: window memory, counters, two dividers, output register
   ppms_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .lon_in         (req_ch.lon_in),
      .lat_in         (req_ch.lat_in),
      .last_in        (req_ch.last_in),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .lon_out        (rsp_ch.lon_out),
      .lat_out        (rsp_ch.lat_out),
      .last_out       (rsp_ch.last_out)
   );

   // input is taken only between words; the output register lets the
   // next word in while a result still waits downstream
   assign req_ch.ready = req_ready;

endmodule
